>>> design/qse_pkg.sv
// Shared types, codes and helpers for the quadrature substep estimator.
`default_nettype none
package qse_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLK_US   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_INV  = 3'd6;

    localparam logic [1:0] MODE_SEED   = 2'd0;
    localparam logic [1:0] MODE_UPDATE = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [31:0] POS_RESET   = 32'd32;
    localparam logic [31:0] SEED_OFFSET = 32'd32;
    localparam logic [3:0]  TT_SCALE    = 4'd13;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TT,
        S_TT_W,
        S_UPD,
        S_SF_W,
        S_HI,
        S_HI_W,
        S_LO,
        S_LO_W,
        S_CLAMP,
        S_MUL,
        S_FIN,
        S_OUT
    } t_state;

    // magnitude of a signed 32-bit word, most negative gives 2^31
    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    // signed quotient from magnitude and sign, saturated to 32 bits
    function automatic logic [31:0] sat_rate(input logic [63:0] q, input logic neg);
        logic [31:0] r;
        if (!neg) begin
            r = (q > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end else begin
            r = (q > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> design/qse_div.sv
// Restoring unsigned divider, 64-bit by 32-bit, one quotient bit a cycle.
`default_nettype none
module qse_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [63:0]      o_quo
);
    import qse_pkg::*;

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [32:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_den;
    logic        r_done;

    logic [32:0] trial;
    logic        fits;

    assign trial = {r_rem[31:0], r_quo[63]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
            r_quo <= {r_quo[62:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider restarted while busy");
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt == 6'd63 && !i_start |=> r_done && !r_busy)
        else $error("divider did not finish after last bit");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held longer than a cycle");

endmodule
`default_nettype wire

>>> design/quadrature_substep_estimator.sv
// Throughput: one item at a time, the next accepted in the cycle after its result is
// loaded; each division holds the shared divider, up to four per update (transition
// time, speed, two bounds).
// Reset (synchronous, active low) restores config defaults, clears the estimator
// state, sets position 32 and flags the encoder stopped.
`default_nettype none
module quadrature_substep_estimator (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [qse_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [qse_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [1:0]                       i_mode,
    input  wire logic [31:0]                      i_step_count,
    input  wire logic signed [31:0]               i_cycle_word,
    input  wire logic [31:0]                      i_timestamp_us,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic signed [31:0]                    o_position_out,
    output logic signed [31:0]                    o_speed_out,
    output logic signed [31:0]                    o_count_out,
    output logic                                  o_stopped_out
);
    import qse_pkg::*;

    t_state r_state, n_state;

    // configuration
    logic [7:0]  r_phase0, r_phase1, r_phase2, r_phase3;
    logic [15:0] r_idle_lim;
    logic [7:0]  r_clk_us;
    logic        r_dir_inv;

    // latched item
    logic [1:0]  r_mode;
    logic [31:0] r_step, r_cw, r_ts;
    logic [31:0] r_tt;
    logic        r_fwd;

    // estimator state
    logic [31:0] r_last_step, r_last_step_time, r_trans_pos, r_trans_time;
    logic [31:0] r_span_low, r_span_high, r_sf, r_sps, r_pos;
    logic [15:0] r_idle;
    logic        r_halted;

    logic [31:0] r_hi, r_lo;
    logic        r_neg;
    logic signed [49:0] r_p1;
    logic signed [63:0] r_p2;

    logic        div_start, div_done;
    logic [63:0] div_num, div_quo;
    logic [31:0] div_den;
    logic        op_neg;

    logic        in_acc, out_free;
    logic        r_out_valid_q;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !o_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    function automatic logic [7:0] phase_sel(input logic [1:0] idx, input logic [7:0] p0,
                                             input logic [7:0] p1, input logic [7:0] p2,
                                             input logic [7:0] p3);
        logic [7:0] r;
        case (idx)
            2'd0:    r = p0;
            2'd1:    r = p1;
            2'd2:    r = p2;
            default: r = p3;
        endcase
        return r;
    endfunction

    logic [31:0] step_inc, low, high, tp;
    assign step_inc = r_step + 32'd1;
    assign low  = {r_step[25:2], phase_sel(r_step[1:0], r_phase0, r_phase1, r_phase2,
                                           r_phase3)};
    assign high = {step_inc[25:2], phase_sel(step_inc[1:0], r_phase0, r_phase1, r_phase2,
                                             r_phase3)};
    assign tp   = r_fwd ? low : high;

    // transition time operands
    logic [31:0] mag;
    logic [35:0] mag13;
    logic [7:0]  clk_div;
    assign mag     = r_cw[31] ? (32'd0 - r_cw) : (32'h8000_0000 - r_cw);
    assign mag13   = {4'd0, mag} * {32'd0, TT_SCALE};
    assign clk_div = (r_clk_us == 8'd0) ? 8'd1 : r_clk_us;

    // idle / halt decisions for an update
    logic        same;
    logic [15:0] idle_n;
    logic        stop, halted1;
    assign same    = (r_step == r_last_step);
    assign idle_n  = same ? ((r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1) : 16'd0;
    assign stop    = !r_halted && (idle_n >= r_idle_lim);
    assign halted1 = r_halted || stop;

    // bound selection
    logic [31:0] d_tl, d_st;
    logic        bnd_sel;
    logic [31:0] bnd_dus, hi_dpos, lo_dpos;
    assign d_tl    = r_trans_time - r_last_step_time;
    assign d_st    = r_ts - r_trans_time;
    assign bnd_sel = (r_trans_time > r_last_step_time) && ($signed(d_tl) > $signed(d_st));
    assign bnd_dus = bnd_sel ? d_tl : d_st;
    assign hi_dpos = bnd_sel ? (r_trans_pos - r_span_low)  : (high - r_trans_pos);
    assign lo_dpos = bnd_sel ? (r_trans_pos - r_span_high) : (low - r_trans_pos);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_mode == MODE_SEED || i_mode == MODE_UPDATE) n_state = S_TT;
                    else n_state = S_OUT;
                end
            end
            S_TT:   n_state = S_TT_W;
            S_TT_W: begin
                if (div_done) n_state = (r_mode == MODE_SEED) ? S_OUT : S_UPD;
            end
            S_UPD: begin
                if (!same && !halted1) n_state = S_SF_W;
                else if (!same || !halted1) n_state = S_HI;
                else n_state = S_FIN;
            end
            S_SF_W:  if (div_done) n_state = S_HI;
            S_HI:    n_state = S_HI_W;
            S_HI_W:  if (div_done) n_state = S_LO;
            S_LO:    n_state = S_LO_W;
            S_LO_W:  if (div_done) n_state = S_CLAMP;
            S_CLAMP: n_state = S_MUL;
            S_MUL:   n_state = S_FIN;
            S_FIN:   n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // divider operands
    logic [31:0] rt_dpos, rt_dus, rt_d;
    always_comb begin
        rt_dpos   = 32'd0;
        rt_dus    = 32'd1;
        div_start = 1'b0;
        case (r_state)
            S_UPD: begin
                rt_dpos   = tp - r_trans_pos;
                rt_dus    = r_tt - r_trans_time;
                div_start = !same && !halted1;
            end
            S_HI: begin
                rt_dpos   = hi_dpos;
                rt_dus    = bnd_dus;
                div_start = 1'b1;
            end
            S_LO: begin
                rt_dpos   = lo_dpos;
                rt_dus    = bnd_dus;
                div_start = 1'b1;
            end
            S_TT:    div_start = 1'b1;
            default: div_start = 1'b0;
        endcase
        rt_d   = (rt_dus == 32'd0) ? 32'd1 : rt_dus;
        op_neg = rt_dpos[31] ^ rt_d[31];
        if (r_state == S_TT) begin
            div_num = {28'd0, mag13};
            div_den = {24'd0, clk_div};
        end else begin
            div_num = {12'd0, abs32(rt_dpos), 20'd0};
            div_den = abs32(rt_d);
        end
    end

    qse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    logic [31:0] tt_new, q_sat, sf_c, sps_new, pos_raw, pos_c, ts_tt;
    assign tt_new  = r_ts - div_quo[31:0];
    assign q_sat   = sat_rate(div_quo, r_neg);
    assign ts_tt   = r_ts - r_tt;
    always_comb begin
        sf_c = r_sf;
        if ($signed(sf_c) > $signed(r_hi)) sf_c = r_hi;
        if ($signed(sf_c) < $signed(r_lo)) sf_c = r_lo;
    end
    assign sps_new = r_p1[47:16];
    assign pos_raw = r_trans_pos + r_p2[51:20];
    always_comb begin
        if ($signed(pos_raw - high) > 0) pos_c = high;
        else if ($signed(pos_raw - low) < 0) pos_c = low;
        else pos_c = pos_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_phase0         <= 8'd0;
            r_phase1         <= 8'd64;
            r_phase2         <= 8'd128;
            r_phase3         <= 8'd192;
            r_idle_lim       <= 16'd30;
            r_clk_us         <= 8'd125;
            r_dir_inv        <= 1'b0;
            r_last_step      <= '0;
            r_last_step_time <= '0;
            r_trans_pos      <= '0;
            r_trans_time     <= '0;
            r_span_low       <= '0;
            r_span_high      <= '0;
            r_idle           <= '0;
            r_sf             <= '0;
            r_sps            <= '0;
            r_pos            <= POS_RESET;
            r_halted         <= 1'b1;
            r_out_valid_q    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_PHASE0:   r_phase0   <= i_cfg_data[7:0];
                    CFG_PHASE1:   r_phase1   <= i_cfg_data[7:0];
                    CFG_PHASE2:   r_phase2   <= i_cfg_data[7:0];
                    CFG_PHASE3:   r_phase3   <= i_cfg_data[7:0];
                    CFG_IDLE_LIM: r_idle_lim <= i_cfg_data;
                    CFG_CLK_US:   r_clk_us   <= i_cfg_data[7:0];
                    CFG_DIR_INV:  r_dir_inv  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_mode == MODE_CLEAR) r_last_step <= '0;
                end
                S_TT_W: begin
                    if (div_done && r_mode == MODE_SEED) begin
                        r_last_step      <= r_step;
                        r_last_step_time <= r_ts;
                        r_trans_time     <= tt_new;
                        r_pos            <= low + SEED_OFFSET;
                    end
                end
                S_UPD: begin
                    r_idle <= idle_n;
                    if (stop) begin
                        r_sps <= '0;
                        r_sf  <= '0;
                    end
                    if (!same) begin
                        r_trans_pos  <= tp;
                        r_trans_time <= r_tt;
                        r_halted     <= 1'b0;
                    end else begin
                        r_halted <= halted1;
                    end
                end
                S_SF_W:  if (div_done) r_sf <= q_sat;
                S_CLAMP: r_sf <= sf_c;
                S_FIN: begin
                    if (!r_halted) begin
                        r_sps <= sps_new;
                        r_pos <= pos_c;
                    end
                    r_span_low       <= low;
                    r_span_high      <= high;
                    r_last_step      <= r_step;
                    r_last_step_time <= r_ts;
                end
                default: ;
            endcase
            if (r_state == S_OUT && out_free) r_out_valid_q <= 1'b1;
            else if (!i_out_stall) r_out_valid_q <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid_q;

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= i_mode;
            r_step <= i_step_count;
            r_cw   <= i_cycle_word;
            r_ts   <= i_timestamp_us;
        end
        if (r_state == S_TT_W && div_done) begin
            r_tt  <= tt_new;
            r_fwd <= r_cw[31];
        end
        if (div_start) r_neg <= op_neg;
        if (r_state == S_HI_W && div_done) r_hi <= q_sat;
        if (r_state == S_LO_W && div_done) r_lo <= q_sat;
        if (r_state == S_MUL) begin
            r_p1 <= $signed(r_sf) * $signed(18'sd62500);
            r_p2 <= $signed(r_sf) * $signed(ts_tt);
        end
        if (r_state == S_OUT && out_free) begin
            o_position_out <= r_dir_inv ? (32'd0 - r_pos) : r_pos;
            o_speed_out    <= r_dir_inv ? (32'd0 - r_sps) : r_sps;
            o_count_out    <= r_dir_inv ? (32'd0 - r_last_step) : r_last_step;
            o_stopped_out  <= r_halted;
        end
    end

    a_halt_zero_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> r_sps == 32'd0) else $error("stopped with nonzero speed");
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE) else $error("accepted item not taken up");
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_TT_W || r_state == S_SF_W || r_state == S_HI_W ||
                      r_state == S_LO_W)) else $error("quotient arrived out of turn");

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the quadrature substep estimator.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import qse_pkg::*;

    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        logic [31:0] pos;
        logic [31:0] spd;
        logic [31:0] cnt;
        logic        stp;
    } t_est;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] step;
        logic [31:0] cw;
        logic [31:0] ts;
        bit          typed;
        t_est        res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [1:0] i_mode = MODE_NONE;
    logic [31:0] i_step_count = '0;
    logic signed [31:0] i_cycle_word = '0;
    logic [31:0] i_timestamp_us = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [31:0] o_position_out, o_speed_out, o_count_out;
    logic o_stopped_out;

    quadrature_substep_estimator dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // estimator shadow state
    logic [7:0]  phase_off [4];
    logic [15:0] stop_limit;
    logic [7:0]  clk_per_us;
    logic        invert;
    logic [31:0] prev_step, prev_time, tr_pos, tr_time, span_lo, span_hi, pos_sub;
    logic [15:0] idle_cnt;
    logic signed [31:0] spd_fix, spd_sec;
    logic        halted;

    t_est expected_q [$];
    int errors = 0;
    int cycles = 0;
    int items_sent = 0;
    int results_seen = 0;
    int stops_seen = 0;
    int burst_left = 0;
    int stall_pct = 0;
    int hold_left = 0;
    bit hold_start = 0, hold_seen = 0;

    task automatic reset_shadow();
        phase_off[0] = 8'd0; phase_off[1] = 8'd64; phase_off[2] = 8'd128; phase_off[3] = 8'd192;
        stop_limit = 16'd30; clk_per_us = 8'd125; invert = 1'b0;
        prev_step = 0; prev_time = 0; tr_pos = 0; tr_time = 0; span_lo = 0; span_hi = 0;
        idle_cnt = 0; spd_fix = 0; spd_sec = 0; pos_sub = 32'd32; halted = 1'b1;
    endtask

    function automatic logic [31:0] step_pos(input logic [31:0] step);
        return ((step << 6) & 32'hFFFF_FF00) | {24'd0, phase_off[step[1:0]]};
    endfunction

    function automatic logic signed [31:0] rate_of(input logic [31:0] dpos, input logic [31:0] dus);
        longint num, den, q;
        num = longint'($signed(dpos)) * 64'sd1048576;
        den = longint'($signed(dus));
        if (den == 0) den = 1;
        q = num / den;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic logic [31:0] trans_at(input logic [31:0] cw, input logic [31:0] ts,
                                             output bit fwd);
        logic [63:0] mag, div;
        div = (clk_per_us == 0) ? 64'd1 : {56'd0, clk_per_us};
        if (cw[31]) begin
            mag = {32'd0, 32'd0 - cw};
            fwd = 1;
        end else begin
            mag = 64'h8000_0000 - {32'd0, cw};
            fwd = 0;
        end
        return ts - 32'((mag * 13) / div);
    endfunction

    function automatic t_est estimate(input logic [1:0] mode, input logic [31:0] step,
                                      input logic [31:0] cw, input logic [31:0] ts);
        bit fwd;
        logic [31:0] tt, lo, hi, tp;
        logic signed [31:0] hi_sp, lo_sp;
        longint prod;
        t_est r;
        if (mode == MODE_SEED) begin
            prev_step = step;
            prev_time = ts;
            tr_time = trans_at(cw, ts, fwd);
            pos_sub = step_pos(step) + SEED_OFFSET;
        end else if (mode == MODE_CLEAR) begin
            prev_step = 0;
        end else if (mode == MODE_UPDATE) begin
            tt = trans_at(cw, ts, fwd);
            lo = step_pos(step);
            hi = step_pos(step + 1);
            if (step == prev_step) begin
                if (idle_cnt != 16'hFFFF) idle_cnt++;
            end else begin
                idle_cnt = 0;
            end
            if (!halted && idle_cnt >= stop_limit) begin
                spd_sec = 0; spd_fix = 0; halted = 1;
            end
            if (prev_step != step) begin
                tp = fwd ? lo : hi;
                if (!halted) spd_fix = rate_of(tp - tr_pos, tt - tr_time);
                halted = 0;
                tr_pos = tp;
                tr_time = tt;
            end
            if (!halted) begin
                if (tr_time > prev_time &&
                    $signed(tr_time - prev_time) > $signed(ts - tr_time)) begin
                    hi_sp = rate_of(tr_pos - span_lo, tr_time - prev_time);
                    lo_sp = rate_of(tr_pos - span_hi, tr_time - prev_time);
                end else begin
                    hi_sp = rate_of(hi - tr_pos, ts - tr_time);
                    lo_sp = rate_of(lo - tr_pos, ts - tr_time);
                end
                if (spd_fix > hi_sp) spd_fix = hi_sp;
                if (spd_fix < lo_sp) spd_fix = lo_sp;
                prod = longint'(spd_fix) * 64'sd62500;
                spd_sec = 32'(prod >>> 16);
                prod = longint'(spd_fix) * longint'($signed(ts - tt));
                pos_sub = tr_pos + 32'(prod >>> 20);
                if ($signed(pos_sub - hi) > 0) pos_sub = hi;
                else if ($signed(pos_sub - lo) < 0) pos_sub = lo;
            end
            span_lo = lo;
            span_hi = hi;
            prev_step = step;
            prev_time = ts;
        end
        r.pos = invert ? 32'd0 - pos_sub : pos_sub;
        r.spd = invert ? 32'd0 - spd_sec : spd_sec;
        r.cnt = invert ? 32'd0 - prev_step : prev_step;
        r.stp = halted;
        return r;
    endfunction

    // Offers one item, with bursts and gaps; returns at the edge it is taken.
    task automatic offer(input logic [1:0] mode, input logic [31:0] step,
                         input logic [31:0] cw, input logic [31:0] ts,
                         input bit typed, input t_est res);
        t_est e;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(6) == 0 ? $urandom_range(40, 1) : $urandom_range(3, 1))
                @(posedge i_clk);
            burst_left = ($urandom_range(3) == 0) ? 200 : $urandom_range(12, 1);
        end
        i_mode <= mode;
        i_step_count <= step;
        i_cycle_word <= cw;
        i_timestamp_us <= ts;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
        items_sent++;
        e = estimate(mode, step, cw, ts);
        expected_q.push_back(typed ? res : e);
    endtask

    task automatic send(input logic [1:0] mode, input logic [31:0] step,
                        input logic [31:0] cw, input logic [31:0] ts);
        offer(mode, step, cw, ts, 0, '0);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_PHASE0, CFG_PHASE1, CFG_PHASE2, CFG_PHASE3: phase_off[idx[1:0]] = val[7:0];
            CFG_IDLE_LIM: stop_limit = val;
            CFG_CLK_US: clk_per_us = val[7:0];
            CFG_DIR_INV: invert = val[0];
            default: ;
        endcase
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off
    always @(posedge i_clk) begin
        if (cycles % 256 == 0) begin
            case ($urandom_range(3))
                0: stall_pct <= 0;
                1: stall_pct <= 25;
                2: stall_pct <= 60;
                default: stall_pct <= 90;
            endcase
        end
        if (hold_start && !hold_seen) begin
            hold_seen <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_est e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                report("unexpected item", o_position_out, 32'd0);
            end else begin
                e = expected_q.pop_front();
                if (o_position_out !== e.pos) report("position", o_position_out, e.pos);
                if (o_speed_out !== e.spd) report("speed", o_speed_out, e.spd);
                if (o_count_out !== e.cnt) report("count", o_count_out, e.cnt);
                if (o_stopped_out !== e.stp) report("stopped", {31'd0, o_stopped_out},
                                                    {31'd0, e.stp});
                if (e.stp) stops_seen++;
            end
        end
    end

    t_row rows [$];
    logic [15:0] cfg_sets [6][7] = '{
        '{16'd0, 16'd64, 16'd128, 16'd192, 16'd30, 16'd125, 16'd0},
        '{16'd255, 16'd255, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1},
        '{16'd17, 16'd200, 16'd3, 16'd99, 16'd65535, 16'd255, 16'd0},
        '{16'd10, 16'd70, 16'd130, 16'd250, 16'd2, 16'd0, 16'd1},
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd5, 16'd50, 16'd0},
        '{16'd200, 16'd150, 16'd100, 16'd50, 16'd12, 16'd200, 16'd1}
    };

    function automatic logic [31:0] pick_cw();
        case ($urandom_range(9))
            0: return $urandom;
            1, 2, 3, 4, 5: return 32'd0 - $urandom_range(4000, 1);
            6, 7, 8: return 32'h7FFF_FFFF - $urandom_range(4000);
            default: case ($urandom_range(2))
                0: return 32'h8000_0000;
                1: return 32'h0000_0000;
                default: return 32'h7FFF_FFFF;
            endcase
        endcase
    endfunction

    initial begin
        logic [31:0] step, ts;
        int n, per_phase;
        reset_shadow();
        rows = '{
            '{MODE_NONE, 32'd0, 32'd0, 32'd0, 1, '{32'd32, 32'd0, 32'd0, 1'b1}},
            '{MODE_CLEAR, 32'd9, 32'd0, 32'd5, 1, '{32'd32, 32'd0, 32'd0, 1'b1}},
            '{MODE_SEED, 32'd0, 32'hFFFF_FFFF, 32'd100, 1, '{32'd32, 32'd0, 32'd0, 1'b1}},
            '{MODE_SEED, 32'd5, 32'hFFFF_FF00, 32'd1000, 0, '0},
            '{MODE_UPDATE, 32'd6, 32'hFFFF_FFF0, 32'd1500, 0, '0},
            '{MODE_UPDATE, 32'd7, 32'hFFFF_FF80, 32'd2000, 0, '0},
            '{MODE_UPDATE, 32'd8, 32'h8000_0000, 32'd2400, 0, '0},
            '{MODE_UPDATE, 32'd8, 32'h7FFF_FFFF, 32'd2400, 0, '0},
            '{MODE_UPDATE, 32'd7, 32'h0000_0000, 32'd2900, 0, '0},
            '{MODE_UPDATE, 32'd6, 32'h7FFF_FF00, 32'd3300, 0, '0},
            '{MODE_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0},
            '{MODE_UPDATE, 32'd0, 32'hFFFF_FFFE, 32'd200, 0, '0},
            '{MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0},
            '{MODE_UPDATE, 32'h8000_0000, 32'h8000_0001, 32'h8000_0000, 0, '0},
            '{MODE_UPDATE, 32'h8000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 0, '0},
            '{MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0},
            '{MODE_UPDATE, 32'd1, 32'hFFFF_FFF8, 32'h8000_0100, 0, '0},
            '{MODE_SEED, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'd0, 0, '0},
            '{MODE_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'd300, 0, '0},
            '{MODE_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'd600, 0, '0}
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[k])
            offer(rows[k].mode, rows[k].step, rows[k].cw, rows[k].ts, rows[k].typed, rows[k].res);
        drain();

        per_phase = 240;
        for (int ph = 0; ph < 6; ph++) begin
            for (int r = 0; r < 7; r++) write_reg(CFG_IDX_W'(r), cfg_sets[ph][r]);
            i_cfg_wr_en <= 1'b0;
            @(posedge i_clk);
            n = 0;
            while (n < per_phase) begin
                if ($urandom_range(9) == 0) begin
                    // noise: any mode, any field values
                    send(2'($urandom_range(3)), $urandom, $urandom, $urandom);
                    n++;
                end else begin
                    step = ($urandom_range(4) == 0) ? $urandom : $urandom_range(1000);
                    ts = $urandom;
                    send(MODE_SEED, step, pick_cw(), ts);
                    n++;
                    for (int k = $urandom_range(40, 5); k > 0 && n < per_phase; k--) begin
                        case ($urandom_range(19))
                            0, 1, 2, 3, 4, 5, 6, 7: step = step + 1;
                            8, 9, 10: step = step - 1;
                            11, 12, 13, 14: ;
                            15: step = step + $urandom_range(8, 2);
                            16: step = $urandom;
                            default: step = step + 1;
                        endcase
                        case ($urandom_range(15))
                            0: ;
                            1: ts = $urandom;
                            2: ts = ts + $urandom_range(200000);
                            default: ts = ts + $urandom_range(3000, 1);
                        endcase
                        if ($urandom_range(29) == 0)
                            send($urandom_range(1) ? MODE_CLEAR : MODE_NONE, step, pick_cw(), ts);
                        else
                            send(MODE_UPDATE, step, pick_cw(), ts);
                        n++;
                        // a run of updates at the same step, so the stop detector may trip
                        if ($urandom_range(24) == 0) begin
                            for (int z = $urandom_range(40, 2); z > 0; z--) begin
                                ts = ts + $urandom_range(1500, 1);
                                send(MODE_UPDATE, step, pick_cw(), ts);
                                n++;
                            end
                        end
                        if (ph == 2 && n >= 100 && !hold_start) hold_start = 1;
                    end
                end
            end
            drain();
        end

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("%0d items sent over 6 register settings, %0d results checked, %0d stopped",
                 items_sent, results_seen, stops_seen);
        $display("covered seed/update/clear/unused modes, word extremes and idle stops");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> filelist.f
design/qse_pkg.sv
design/qse_div.sv
design/quadrature_substep_estimator.sv
tb/tb.sv
